/* sv/kruskal_max_spacing_clustering_top_defines.svh */
// ----------------------------------------------------------------------------
// kruskal max-spacing clustering: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_MAX_SPACING_CLUSTERING_TOP_DEFINES_SVH
`define KRUSKAL_MAX_SPACING_CLUSTERING_TOP_DEFINES_SVH

// property that holds at every clock edge
`define KMSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define KMSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/kmsc_pkg.sv */
// ----------------------------------------------------------------------------
// kmsc_pkg
// Types, codes and constants shared by the clustering engine modules.
// ----------------------------------------------------------------------------
package kmsc_pkg;

   localparam int DEF_MAX_NODES = 1024;
   localparam int DEF_COST_BITS = 16;

   // configuration registers
   localparam int CFG_W          = 11;
   localparam int CSR_IDX_W      = 1;
   localparam int RST_NODE_COUNT = 1024;
   localparam int RST_TARGET     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET     = 1'd1;

   // union-by-rank
   localparam int RANK_W = 4;
   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   // input action
   localparam logic ACT_START = 1'b0;

   // result status
   localparam int STATUS_W = 3;
   localparam logic [STATUS_W-1:0] STAT_SAME     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_MERGED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_SPACING  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FINISHED = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_STARTED  = 3'd4;

   typedef struct packed {
      logic                take;        // latch the accepted word
      logic                start;       // load fresh-run state
      logic                clear;       // write one reset entry of the sweep
      logic                issue;       // read the endpoint of the current side
      logic                walk1;       // root search step
      logic                walk2;       // compression step
      logic                side;        // 0 endpoint a, 1 endpoint b
      logic                join_roots;  // link the two roots, drop the count
      logic                link_rank;   // raise the rank of root a
      logic                finish;      // record the spacing
      logic                load_rsp;    // fill the result register
      logic [STATUS_W-1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_match;      // read parent equals the node read
      logic at_root;         // read parent equals the side's root
      logic roots_equal;
      logic rank_equal;
      logic target_reached;
      logic finished;
      logic range_bad;       // an endpoint of the offered word is out of range
      logic out_busy;        // result register holds an untaken word
   } dp_stat_type;

endpackage

/* sv/kmsc_ctrl.sv */
// ----------------------------------------------------------------------------
// kmsc_ctrl
// Sequencer for the clustering engine: memory sweep, the two root walks with
// compression per endpoint, the join decision and result hand-off.
// ----------------------------------------------------------------------------
module kmsc_ctrl import kmsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_action,
   output logic        req_tready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_ISSUE1 = 4'd2;
   localparam logic [3:0] ST_WALK1  = 4'd3;
   localparam logic [3:0] ST_ISSUE2 = 4'd4;
   localparam logic [3:0] ST_WALK2  = 4'd5;
   localparam logic [3:0] ST_DECIDE = 4'd6;
   localparam logic [3:0] ST_LINK   = 4'd7;
   localparam logic [3:0] ST_RESP   = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic                side_ff, side_in;
   logic                boot_ff, boot_in;
   logic [STATUS_W-1:0] code_ff, code_in;

   always_comb begin
      state_in          = state_ff;
      side_in           = side_ff;
      boot_in           = boot_ff;
      code_in           = code_ff;
      req_tready        = 1'b0;
      dp_cmd            = '0;
      dp_cmd.side       = side_ff;
      dp_cmd.rsp_status = code_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear = 1'b1;
            if (dp_stat.clear_done) begin
               boot_in  = 1'b0;
               // the sweep after reset gives no result word
               state_in = boot_ff ? ST_IDLE : ST_RESP;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.take = 1'b1;
               priority if (req_action == ACT_START) begin
                  dp_cmd.start = 1'b1;
                  code_in      = STAT_STARTED;
                  state_in     = ST_CLEAR;
               end else if (dp_stat.finished) begin
                  code_in  = STAT_FINISHED;
                  state_in = ST_RESP;
               end else if (dp_stat.range_bad) begin
                  code_in  = STAT_SAME;
                  state_in = ST_RESP;
               end else begin
                  side_in  = 1'b0;
                  state_in = ST_ISSUE1;
               end
            end
         end
         ST_ISSUE1: begin
            dp_cmd.issue = 1'b1;
            state_in     = ST_WALK1;
         end
         ST_WALK1: begin
            dp_cmd.walk1 = 1'b1;
            if (dp_stat.walk_match) begin
               state_in = ST_ISSUE2;
            end
         end
         ST_ISSUE2: begin
            dp_cmd.issue = 1'b1;
            state_in     = ST_WALK2;
         end
         ST_WALK2: begin
            dp_cmd.walk2 = 1'b1;
            if (dp_stat.at_root) begin
               if (side_ff) begin
                  state_in = ST_DECIDE;
               end else begin
                  side_in  = 1'b1;
                  state_in = ST_ISSUE1;
               end
            end
         end
         ST_DECIDE: begin
            priority if (dp_stat.roots_equal) begin
               code_in  = STAT_SAME;
               state_in = ST_RESP;
            end else if (dp_stat.target_reached) begin
               dp_cmd.finish = 1'b1;
               code_in       = STAT_SPACING;
               state_in      = ST_RESP;
            end else begin
               dp_cmd.join_roots = 1'b1;
               code_in           = STAT_MERGED;
               state_in          = dp_stat.rank_equal ? ST_LINK : ST_RESP;
            end
         end
         ST_LINK: begin
            dp_cmd.link_rank = 1'b1;
            state_in         = ST_RESP;
         end
         ST_RESP: begin
            if (!dp_stat.out_busy) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         side_ff  <= 1'b0;
         boot_ff  <= 1'b1;
         code_ff  <= STAT_SAME;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         boot_ff  <= boot_in;
         code_ff  <= code_in;
      end
   end

endmodule

/* sv/kmsc_datapath.sv */
// ----------------------------------------------------------------------------
// kmsc_datapath
// Parent/rank memory, root and walk registers, run state, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
`include "kruskal_max_spacing_clustering_top_defines.svh"

module kmsc_datapath import kmsc_pkg::*; #(
   parameter  int MAX_NODES = DEF_MAX_NODES,
   parameter  int COST_BITS = DEF_COST_BITS,
   localparam int NODE_W    = $clog2(MAX_NODES),
   localparam int CNT_W     = $clog2(MAX_NODES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [NODE_W-1:0]    req_node_a,
   input  logic [NODE_W-1:0]    req_node_b,
   input  logic [COST_BITS-1:0] req_edge_cost,
   input  dp_cmd_type           dp_cmd,
   output dp_stat_type          dp_stat,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COST_BITS-1:0] rsp_spacing,
   output logic [CNT_W-1:0]     rsp_clusters
);

   localparam int CMP_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
   localparam int ENTRY_W   = NODE_W + RANK_W;
   localparam int RST_COUNT = (RST_NODE_COUNT > MAX_NODES) ? MAX_NODES : RST_NODE_COUNT;
   localparam logic RST_REACHED = (RST_COUNT <= RST_TARGET);
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);
   localparam logic [CMP_W-1:0]  MAX_CMP   = CMP_W'(MAX_NODES);

   // entry: parent in the upper bits, rank in the lower bits
   logic [ENTRY_W-1:0] node_mem_ff [MAX_NODES];
   logic [ENTRY_W-1:0] rd_ff;

   logic                 mem_we;
   logic [NODE_W-1:0]    mem_waddr;
   logic [ENTRY_W-1:0]   mem_wdata;
   logic [NODE_W-1:0]    mem_raddr;

   logic [NODE_W-1:0]    a_ff, a_in;
   logic [NODE_W-1:0]    b_ff, b_in;
   logic [COST_BITS-1:0] cost_ff, cost_in;
   logic [CFG_W-1:0]     node_count_ff, node_count_in;
   logic [CFG_W-1:0]     target_ff, target_in;
   logic [CNT_W-1:0]     cluster_count_ff, cluster_count_in;
   logic                 target_reached_ff, target_reached_in;
   logic                 finished_ff, finished_in;
   logic [COST_BITS-1:0] found_spacing_ff, found_spacing_in;
   logic [NODE_W-1:0]    clr_ff, clr_in;
   logic [NODE_W-1:0]    cur_ff, cur_in;
   logic [NODE_W-1:0]    root_a_ff, root_a_in;
   logic [NODE_W-1:0]    root_b_ff, root_b_in;
   logic [RANK_W-1:0]    rank_a_ff, rank_a_in;
   logic [RANK_W-1:0]    rank_b_ff, rank_b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COST_BITS-1:0] rsp_spacing_ff, rsp_spacing_in;
   logic [CNT_W-1:0]     rsp_clusters_ff, rsp_clusters_in;

   logic [NODE_W-1:0]    rd_parent;
   logic [RANK_W-1:0]    rd_rank;
   logic [NODE_W-1:0]    endpoint;
   logic [NODE_W-1:0]    root_side;
   logic [CMP_W-1:0]     active_cmp;
   logic [CNT_W-1:0]     dec_count;
   logic [RANK_W-1:0]    rank_inc;

   assign rd_parent = rd_ff[ENTRY_W-1:RANK_W];
   assign rd_rank   = rd_ff[RANK_W-1:0];
   assign endpoint  = dp_cmd.side ? b_ff : a_ff;
   assign root_side = dp_cmd.side ? root_b_ff : root_a_ff;
   assign mem_raddr = dp_cmd.issue ? endpoint : rd_parent;

   // node count capped at the memory depth
   assign active_cmp = (CMP_W'(node_count_ff) > MAX_CMP) ? MAX_CMP : CMP_W'(node_count_ff);
   assign dec_count  = (cluster_count_ff != '0) ? cluster_count_ff - 1'b1 : cluster_count_ff;
   assign rank_inc   = (rank_a_ff == RANK_MAX) ? rank_a_ff : rank_a_ff + 1'b1;

   always_comb begin
      dp_stat.clear_done     = (clr_ff == LAST_NODE);
      dp_stat.walk_match     = (rd_parent == cur_ff);
      dp_stat.at_root        = (rd_parent == root_side);
      dp_stat.roots_equal    = (root_a_ff == root_b_ff);
      dp_stat.rank_equal     = (rank_a_ff == rank_b_ff);
      dp_stat.target_reached = target_reached_ff;
      dp_stat.finished       = finished_ff;
      dp_stat.range_bad      = (CMP_W'(req_node_a) >= active_cmp) ||
                               (CMP_W'(req_node_b) >= active_cmp);
      dp_stat.out_busy       = rsp_valid_ff && !rsp_tready;
   end

   // single write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = {clr_ff, RANK_W'(0)};
      if (dp_cmd.clear) begin
         mem_we = 1'b1;
      end else if (dp_cmd.walk2 && !dp_stat.at_root) begin
         // point the node straight at its root
         mem_we    = 1'b1;
         mem_waddr = cur_ff;
         mem_wdata = {root_side, rd_rank};
      end else if (dp_cmd.join_roots) begin
         mem_we = 1'b1;
         if (rank_a_ff < rank_b_ff) begin
            mem_waddr = root_a_ff;
            mem_wdata = {root_b_ff, rank_a_ff};
         end else begin
            mem_waddr = root_b_ff;
            mem_wdata = {root_a_ff, rank_b_ff};
         end
      end else if (dp_cmd.link_rank) begin
         mem_we    = 1'b1;
         mem_waddr = root_a_ff;
         mem_wdata = {root_a_ff, rank_inc};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_ff <= node_mem_ff[mem_raddr];
   end

   always_comb begin
      a_in              = dp_cmd.take ? req_node_a : a_ff;
      b_in              = dp_cmd.take ? req_node_b : b_ff;
      cost_in           = dp_cmd.take ? req_edge_cost : cost_ff;
      node_count_in     = node_count_ff;
      target_in         = target_ff;
      cluster_count_in  = cluster_count_ff;
      target_reached_in = target_reached_ff;
      finished_in       = finished_ff;
      found_spacing_in  = found_spacing_ff;
      clr_in            = clr_ff;
      cur_in            = cur_ff;
      root_a_in         = root_a_ff;
      root_b_in         = root_b_ff;
      rank_a_in         = rank_a_ff;
      rank_b_in         = rank_b_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_status_in     = rsp_status_ff;
      rsp_spacing_in    = rsp_spacing_ff;
      rsp_clusters_in   = rsp_clusters_ff;

      if (csr_we && (csr_index == CSR_NODE_COUNT)) begin
         node_count_in = csr_wdata;
      end
      if (csr_we && (csr_index == CSR_TARGET)) begin
         target_in = csr_wdata;
      end

      if (dp_cmd.start) begin
         cluster_count_in  = active_cmp[CNT_W-1:0];
         target_reached_in = (active_cmp <= CMP_W'(target_ff));
         finished_in       = 1'b0;
         found_spacing_in  = '0;
         clr_in            = '0;
      end else if (dp_cmd.clear) begin
         clr_in = clr_ff + 1'b1;
      end

      if (dp_cmd.issue) begin
         cur_in = endpoint;
      end else if (dp_cmd.walk1 || dp_cmd.walk2) begin
         cur_in = rd_parent;
      end

      if (dp_cmd.walk1 && dp_stat.walk_match) begin
         if (dp_cmd.side) begin
            root_b_in = cur_ff;
            rank_b_in = rd_rank;
         end else begin
            root_a_in = cur_ff;
            rank_a_in = rd_rank;
         end
      end

      if (dp_cmd.join_roots) begin
         cluster_count_in  = dec_count;
         target_reached_in = target_reached_ff || (CMP_W'(dec_count) <= CMP_W'(target_ff));
      end

      if (dp_cmd.finish) begin
         finished_in      = 1'b1;
         found_spacing_in = cost_ff;
      end

      if (dp_cmd.load_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = dp_cmd.rsp_status;
         rsp_spacing_in  = finished_ff ? found_spacing_ff : '0;
         rsp_clusters_in = cluster_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff     <= CFG_W'(RST_NODE_COUNT);
         target_ff         <= CFG_W'(RST_TARGET);
         cluster_count_ff  <= CNT_W'(RST_COUNT);
         target_reached_ff <= RST_REACHED;
         finished_ff       <= 1'b0;
         found_spacing_ff  <= '0;
         clr_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         node_count_ff     <= node_count_in;
         target_ff         <= target_in;
         cluster_count_ff  <= cluster_count_in;
         target_reached_ff <= target_reached_in;
         finished_ff       <= finished_in;
         found_spacing_ff  <= found_spacing_in;
         clr_ff            <= clr_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff            <= a_in;
      b_ff            <= b_in;
      cost_ff         <= cost_in;
      cur_ff          <= cur_in;
      root_a_ff       <= root_a_in;
      root_b_ff       <= root_b_in;
      rank_a_ff       <= rank_a_in;
      rank_b_ff       <= rank_b_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_spacing_ff  <= rsp_spacing_in;
      rsp_clusters_ff <= rsp_clusters_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_spacing  = rsp_spacing_ff;
   assign rsp_clusters = rsp_clusters_ff;

   `KMSC_ASSERT(a_finish_needs_target, !finished_ff || target_reached_ff, "finished below target")
   `KMSC_ASSERT(a_no_result_overwrite, !(dp_cmd.load_rsp && dp_stat.out_busy), "result word lost")
   `KMSC_ASSERT_NEXT(a_join_drops_count, dp_cmd.join_roots && (cluster_count_ff != '0), cluster_count_ff == $past(cluster_count_ff) - 1'b1, "join did not drop count")

endmodule

/* sv/kruskal_max_spacing_clustering_top.sv */
// ----------------------------------------------------------------------------
// kruskal_max_spacing_clustering_top
// Union-find engine for max-spacing k-clustering over cost-ordered edges.
// ----------------------------------------------------------------------------
// edge word: per endpoint an issue, a root walk and a compression walk, then the join
//   decision, a rank link when a join finds the two root ranks tie, and the result
// start word: memory rewrite of all MAX_NODES entries (1024 by default), then the result
// ignored or post-finish edges: straight to the result; next word taken once it is loaded
// reset: synchronous, active high; a sweep of all MAX_NODES entries follows before req_tready
module kruskal_max_spacing_clustering_top import kmsc_pkg::*; #(
   parameter  int MAX_NODES  = DEF_MAX_NODES,
   parameter  int COST_BITS  = DEF_COST_BITS,
   localparam int NODE_W     = $clog2(MAX_NODES),
   localparam int CNT_W      = $clog2(MAX_NODES + 1),
   localparam int REQ_DATA_W = ((2 * NODE_W + COST_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((COST_BITS + CNT_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // node_a, node_b, edge_cost
   input  logic                  req_tuser,   // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // spacing, clusters
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   dp_cmd_type dp_cmd;
   dp_stat_type dp_stat;

   logic [NODE_W-1:0]    req_node_a;
   logic [NODE_W-1:0]    req_node_b;
   logic [COST_BITS-1:0] req_edge_cost;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COST_BITS-1:0] rsp_spacing;
   logic [CNT_W-1:0]     rsp_clusters;

   assign req_node_a    = req_tdata[NODE_W-1:0];
   assign req_node_b    = req_tdata[2*NODE_W-1:NODE_W];
   assign req_edge_cost = req_tdata[2*NODE_W+COST_BITS-1:2*NODE_W];

   kmsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   kmsc_datapath #(
      .MAX_NODES (MAX_NODES),
      .COST_BITS (COST_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_node_a    (req_node_a),
      .req_node_b    (req_node_b),
      .req_edge_cost (req_edge_cost),
      .dp_cmd        (dp_cmd),
      .dp_stat       (dp_stat),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_status    (rsp_status),
      .rsp_spacing   (rsp_spacing),
      .rsp_clusters  (rsp_clusters)
   );

   // result word, zero-filled to whole bytes
   assign rsp_tdata = RSP_DATA_W'({rsp_clusters, rsp_spacing});
   assign rsp_tuser = rsp_status;

endmodule
